@@ hw/rtl/dsadc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsadc_pkg - shared types and constants of the dual-slope adc sequencer
// payload structs, queue entry, phase and back-end state codes, widths
// ----------------------------------------------------------------------------
package dsadc_pkg;

    // fine counter width
    localparam int COUNT_WIDTH = 16;
    // width used to compare the incremented fine count with the period
    localparam int CMP_W = (COUNT_WIDTH + 1 > 16) ? COUNT_WIDTH + 1 : 16;

    localparam int PERIOD_W = 16;
    localparam int FS_W     = 16;
    localparam int OVF_W    = 16;
    localparam int NUM_W    = 32;
    // total count n = fine + period * overflows
    localparam int N_W      = ((COUNT_WIDTH > PERIOD_W + OVF_W) ?
                               COUNT_WIDTH : PERIOD_W + OVF_W) + 1;
    localparam int REM_W    = N_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_MV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR       = 2'd2;

    localparam logic [PERIOD_W-1:0] RST_OVERFLOW_PERIOD = 16'd8471;
    localparam logic [FS_W-1:0]     RST_FULL_SCALE_MV   = 16'd3300;
    localparam logic [NUM_W-1:0]    RST_NUMERATOR       = 32'd14400700;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REF,
        PH_VIN
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FIN
    } t_bk_state;

    typedef struct packed {
        logic period_start;
        logic comparator;
    } t_in_item;

    typedef struct packed {
        logic            reference_applied;
        logic [FS_W-1:0] voltage_mv;
        logic            value_valid;
        logic            over_range;
    } t_out_item;

    // one pending result as classified by the front end
    typedef struct packed {
        logic                   measure;
        logic                   over;
        logic                   ref_applied;
        logic [COUNT_WIDTH-1:0] fine;
        logic [OVF_W-1:0]       ovf;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

@@ hw/rtl/dual_slope_adc_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// dual_slope_adc_sequencer_unit - dual-slope adc conversion sequencer
// one input transfer per count-clock tick, results on a stalling channel
// ----------------------------------------------------------------------------
// result path: a switch-only or over-range result passes the queue, then the
//   output register; a measurement passes multiply, 32 divider steps and
//   clamp
// throughput: one tick per cycle while the 4-entry queue has room; the back
//   end is held for each measurement by the one-bit-a-cycle divider
// reset: synchronous active-low, clears phase, counters, queue, back end and
//   restores the register defaults; no clearing pass
module dual_slope_adc_sequencer_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // tick input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  dsadc_pkg::t_in_item                    i_in_data,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output dsadc_pkg::t_out_item                   o_out_data,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dsadc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dsadc_pkg::NUM_W-1:0]            i_cfg_data
);

    // configuration registers
    logic [dsadc_pkg::PERIOD_W-1:0] r_overflow_period, n_overflow_period;
    logic [dsadc_pkg::FS_W-1:0]     r_full_scale_mv, n_full_scale_mv;
    logic [dsadc_pkg::NUM_W-1:0]    r_numerator, n_numerator;

    logic                  w_cfg_we;
    logic                  w_accept;
    logic                  w_push;
    logic                  w_pop;
    dsadc_pkg::t_job       w_job;
    dsadc_pkg::t_job       w_head;
    dsadc_pkg::t_fifo_stat w_stat;

    // writes are always taken; an index past the list is dropped
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_overflow_period = r_overflow_period;
        n_full_scale_mv   = r_full_scale_mv;
        n_numerator       = r_numerator;
        if (w_cfg_we) begin
            case (i_cfg_index)
                dsadc_pkg::CFG_OVERFLOW_PERIOD: begin
                    n_overflow_period = i_cfg_data[dsadc_pkg::PERIOD_W-1:0];
                end
                dsadc_pkg::CFG_FULL_SCALE_MV: begin
                    n_full_scale_mv = i_cfg_data[dsadc_pkg::FS_W-1:0];
                end
                dsadc_pkg::CFG_NUMERATOR: begin
                    n_numerator = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow_period <= dsadc_pkg::RST_OVERFLOW_PERIOD;
            r_full_scale_mv   <= dsadc_pkg::RST_FULL_SCALE_MV;
            r_numerator       <= dsadc_pkg::RST_NUMERATOR;
        end else begin
            r_overflow_period <= n_overflow_period;
            r_full_scale_mv   <= n_full_scale_mv;
            r_numerator       <= n_numerator;
        end
    end

    // input stalls only while the queue is full, so ticks are never lost
    assign o_in_stall = w_stat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // front end: phase sequencing and edge detection, one tick a cycle while the input is not stalled
    dsadc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (w_accept),
        .i_item            (i_in_data),
        .i_overflow_period (r_overflow_period),
        .o_push            (w_push),
        .o_job             (w_job)
    );

    // ticks that cause a result wait here for the back end
    dsadc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // back end: total count, divide, clamp and output register
    dsadc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (w_head),
        .i_job_avail       (!w_stat.empty),
        .o_pop             (w_pop),
        .i_overflow_period (r_overflow_period),
        .i_full_scale_mv   (r_full_scale_mv),
        .i_numerator       (r_numerator),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_data        (o_out_data)
    );

    // a classified tick never finds the queue full
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("job pushed into a full queue");

    // the back end only takes from a non-empty queue
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("job popped from an empty queue");

    // an over-range result is a valid full-scale reading
    a_over_is_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.over_range) |->
            (o_out_data.value_valid && o_out_data.voltage_mv == r_full_scale_mv))
        else $error("over-range result without full-scale value");

endmodule

@@ hw/rtl/dsadc_front.sv @@
// ----------------------------------------------------------------------------
// dsadc_front - tick front end
// counts the phases, detects comparator edges and classifies each tick
// ----------------------------------------------------------------------------
module dsadc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  dsadc_pkg::t_in_item                 i_item,
    input  logic [dsadc_pkg::PERIOD_W-1:0]      i_overflow_period,
    output logic                                o_push,
    output dsadc_pkg::t_job                     o_job
);

    dsadc_pkg::t_phase                     r_phase, n_phase;
    logic [dsadc_pkg::COUNT_WIDTH-1:0]     r_fine, n_fine;
    logic [dsadc_pkg::OVF_W-1:0]           r_ovf, n_ovf;
    logic                                  r_last_comp, n_last_comp;
    logic                                  r_switch, n_switch;

    logic [dsadc_pkg::COUNT_WIDTH:0]       w_next;
    logic [dsadc_pkg::CMP_W-1:0]           w_next_ext;
    logic [dsadc_pkg::CMP_W-1:0]           w_per_ext;
    logic                                  w_wrap;
    logic                                  w_measure;
    logic                                  w_over;

    assign w_next     = {1'b0, r_fine} + (dsadc_pkg::COUNT_WIDTH + 1)'(1);
    assign w_next_ext = dsadc_pkg::CMP_W'(w_next);
    assign w_per_ext  = dsadc_pkg::CMP_W'(i_overflow_period);
    // wrap at the period or past the top of the counter
    assign w_wrap     = (w_next_ext >= w_per_ext) || w_next[dsadc_pkg::COUNT_WIDTH];

    always_comb begin
        n_phase     = r_phase;
        n_fine      = r_fine;
        n_ovf       = r_ovf;
        n_last_comp = r_last_comp;
        n_switch    = r_switch;
        w_measure   = 1'b0;
        w_over      = 1'b0;
        if (i_accept) begin
            // counting by the phase at the start of the tick
            if (r_phase != dsadc_pkg::PH_IDLE) begin
                if (w_wrap) begin
                    n_fine = '0;
                    if (r_phase == dsadc_pkg::PH_REF) begin
                        n_phase  = dsadc_pkg::PH_VIN;
                        n_switch = 1'b0;
                    end else if (r_ovf != '1) begin
                        n_ovf = r_ovf + dsadc_pkg::OVF_W'(1);
                    end
                end else begin
                    n_fine = w_next[dsadc_pkg::COUNT_WIDTH-1:0];
                end
            end
            // comparator edges
            if (i_item.comparator && !r_last_comp) begin
                n_fine  = '0;
                n_ovf   = '0;
                n_phase = dsadc_pkg::PH_REF;
            end else if (!i_item.comparator && r_last_comp) begin
                w_measure = 1'b1;
                n_phase   = dsadc_pkg::PH_IDLE;
            end
            n_last_comp = i_item.comparator;
            // period strobe
            if (i_item.period_start) begin
                if (n_phase == dsadc_pkg::PH_VIN) begin
                    w_over = 1'b1;
                end
                n_switch = 1'b1;
            end
        end
    end

    assign o_push = i_accept && (w_measure || w_over || (n_switch != r_switch));

    always_comb begin
        o_job.measure     = w_measure;
        o_job.over        = w_over;
        o_job.ref_applied = n_switch;
        o_job.fine        = n_fine;
        o_job.ovf         = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dsadc_pkg::PH_IDLE;
            r_fine      <= '0;
            r_ovf       <= '0;
            r_last_comp <= 1'b0;
            r_switch    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_fine      <= n_fine;
            r_ovf       <= n_ovf;
            r_last_comp <= n_last_comp;
            r_switch    <= n_switch;
        end
    end

endmodule

@@ hw/rtl/dsadc_fifo.sv @@
// ----------------------------------------------------------------------------
// dsadc_fifo - short job queue
// decouples the tick front end from the slow back end
// ----------------------------------------------------------------------------
module dsadc_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dsadc_pkg::t_job       i_job,
    input  logic                  i_pop,
    output dsadc_pkg::t_job       o_head,
    output dsadc_pkg::t_fifo_stat o_stat
);

    dsadc_pkg::t_job                  r_mem [dsadc_pkg::FIFO_DEPTH];
    logic [dsadc_pkg::FIFO_AW-1:0]    r_wr, n_wr;
    logic [dsadc_pkg::FIFO_AW-1:0]    r_rd, n_rd;
    logic [dsadc_pkg::FIFO_AW:0]      r_cnt, n_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (dsadc_pkg::FIFO_AW + 1)'(dsadc_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + dsadc_pkg::FIFO_AW'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + dsadc_pkg::FIFO_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (dsadc_pkg::FIFO_AW + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (dsadc_pkg::FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/dsadc_back.sv @@
// ----------------------------------------------------------------------------
// dsadc_back - result back end
// total count multiply, radix-2 divider and output register
// ----------------------------------------------------------------------------
module dsadc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dsadc_pkg::t_job                   i_job,
    input  logic                              i_job_avail,
    output logic                              o_pop,
    input  logic [dsadc_pkg::PERIOD_W-1:0]    i_overflow_period,
    input  logic [dsadc_pkg::FS_W-1:0]        i_full_scale_mv,
    input  logic [dsadc_pkg::NUM_W-1:0]       i_numerator,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dsadc_pkg::t_out_item              o_out_data
);

    dsadc_pkg::t_bk_state                   r_state, n_state;
    logic [dsadc_pkg::COUNT_WIDTH-1:0]      r_fine, n_fine;
    logic [dsadc_pkg::OVF_W-1:0]            r_ovf, n_ovf;
    logic                                   r_ref, n_ref;
    logic [dsadc_pkg::N_W-1:0]              r_n, n_n;
    logic [dsadc_pkg::REM_W-1:0]            r_rem, n_rem;
    logic [dsadc_pkg::NUM_W-1:0]            r_quo, n_quo;
    logic [dsadc_pkg::DIV_CNT_W-1:0]        r_cnt, n_cnt;
    logic                                   r_out_valid, n_out_valid;
    dsadc_pkg::t_out_item                   r_out, n_out;

    logic                                   w_out_free;
    logic [dsadc_pkg::PERIOD_W+dsadc_pkg::OVF_W-1:0] w_prod;
    logic [dsadc_pkg::REM_W-1:0]            w_rem_sh;
    logic                                   w_ge;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_prod     = i_overflow_period * r_ovf;
    assign w_rem_sh   = {r_rem[dsadc_pkg::REM_W-2:0], r_quo[dsadc_pkg::NUM_W-1]};
    assign w_ge       = (w_rem_sh >= dsadc_pkg::REM_W'(r_n));

    always_comb begin
        n_state     = r_state;
        n_fine      = r_fine;
        n_ovf       = r_ovf;
        n_ref       = r_ref;
        n_n         = r_n;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            dsadc_pkg::BK_IDLE: begin
                if (i_job_avail) begin
                    if (i_job.measure) begin
                        o_pop   = 1'b1;
                        n_fine  = i_job.fine;
                        n_ovf   = i_job.ovf;
                        n_ref   = i_job.ref_applied;
                        n_state = dsadc_pkg::BK_MUL;
                    end else if (w_out_free) begin
                        o_pop                   = 1'b1;
                        n_out_valid             = 1'b1;
                        n_out.reference_applied = i_job.ref_applied;
                        n_out.voltage_mv        = i_job.over ? i_full_scale_mv : '0;
                        n_out.value_valid       = i_job.over;
                        n_out.over_range        = i_job.over;
                    end
                end
            end
            dsadc_pkg::BK_MUL: begin
                n_n     = dsadc_pkg::N_W'(w_prod) + dsadc_pkg::N_W'(r_fine);
                n_rem   = '0;
                n_quo   = i_numerator;
                n_cnt   = dsadc_pkg::DIV_CNT_W'(dsadc_pkg::NUM_W - 1);
                n_state = dsadc_pkg::BK_DIV;
            end
            dsadc_pkg::BK_DIV: begin
                // one quotient bit a cycle, msb first
                n_rem = w_ge ? (w_rem_sh - dsadc_pkg::REM_W'(r_n)) : w_rem_sh;
                n_quo = {r_quo[dsadc_pkg::NUM_W-2:0], w_ge};
                n_cnt = r_cnt - dsadc_pkg::DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = dsadc_pkg::BK_FIN;
                end
            end
            dsadc_pkg::BK_FIN: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.reference_applied = r_ref;
                    n_out.value_valid       = 1'b1;
                    n_out.over_range        = 1'b0;
                    // zero count and quotient at or above full scale clamp to 0
                    if (r_n == '0 ||
                        r_quo >= dsadc_pkg::NUM_W'(i_full_scale_mv)) begin
                        n_out.voltage_mv = '0;
                    end else begin
                        n_out.voltage_mv = i_full_scale_mv
                                           - r_quo[dsadc_pkg::FS_W-1:0];
                    end
                    n_state = dsadc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = dsadc_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        r_fine <= n_fine;
        r_ovf  <= n_ovf;
        r_ref  <= n_ref;
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsadc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
